// ===== sv/arts_pkg.sv =====
// Shared types, constants and the microcode program of the artanh series summer.
// Used by arts_div and artanh_series_summer; depends on nothing else.
`timescale 1ns / 1ps

package arts_pkg;

  localparam int FRAC_BITS = 31;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 34;
  localparam int EST_W     = 31;
  localparam int REM_W     = SUM_W + 1;
  localparam int IDX_W     = 6;
  localparam int PC_W      = 4;
  localparam int CNT_W     = 6;
  localparam int DATA_W    = 104;

  localparam logic [EST_W-1:0] EST_CAP  = '1;
  localparam logic [EST_W-1:0] TERM_CAP = '1;

  localparam logic [CNT_W-1:0] DIV_TERM_STEPS = CNT_W'(VAL_W);
  localparam logic [CNT_W-1:0] DIV_EST_STEPS  = CNT_W'(FRAC_BITS);

  localparam logic [1:0] CFG_STOP_MODE  = 2'd0;
  localparam logic [1:0] CFG_TERM_LIMIT = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd2;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_TERM     = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV_NEXT = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV_EST  = 4'd7;
  localparam logic [PC_W-1:0] PC_WAIT     = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_MUL_X2,
    OP_SET_X2,
    OP_TERM,
    OP_PNEXT,
    OP_DIV,
    OP_NMAG,
    OP_EST,
    OP_EMIT,
    OP_ADVANCE
  } uop_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_REQ,
    JC_DIV_MORE,
    JC_SKIP,
    JC_OUT_FULL,
    JC_LAST
  } jcond_t;

  typedef struct packed {
    uop_t            op;
    jcond_t          cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [CNT_W-1:0] steps;
  } div_ctrl_t;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_ACCEPT,  JC_NO_REQ,   PC_IDLE};
      4'd1:    w = '{OP_MUL_X2,  JC_NEVER,    PC_IDLE};
      4'd2:    w = '{OP_SET_X2,  JC_NEVER,    PC_IDLE};
      4'd3:    w = '{OP_TERM,    JC_NEVER,    PC_IDLE};
      4'd4:    w = '{OP_PNEXT,   JC_NEVER,    PC_IDLE};
      4'd5:    w = '{OP_DIV,     JC_DIV_MORE, PC_DIV_NEXT};
      4'd6:    w = '{OP_NMAG,    JC_SKIP,     PC_WAIT};
      4'd7:    w = '{OP_DIV,     JC_DIV_MORE, PC_DIV_EST};
      4'd8:    w = '{OP_EST,     JC_NEVER,    PC_IDLE};
      4'd9:    w = '{OP_NOP,     JC_OUT_FULL, PC_WAIT};
      4'd10:   w = '{OP_EMIT,    JC_LAST,     PC_IDLE};
      4'd11:   w = '{OP_ADVANCE, JC_ALWAYS,   PC_TERM};
      default: w = '{OP_NOP,     JC_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

  // Product shifted down by the fraction width, rounded half up.
  function automatic logic [VAL_W-1:0] round_shift(input logic [2*VAL_W-1:0] p);
    logic [2*VAL_W-1:0] s;
    s = p + ((2*VAL_W)'(1) << (FRAC_BITS - 1));
    return s[FRAC_BITS+VAL_W-1:FRAC_BITS];
  endfunction

endpackage

// ===== sv/arts_div.sv =====
// Shared restoring divider of the artanh series summer, one quotient bit a cycle.
// Depends on arts_pkg for widths and the control struct.
`timescale 1ns / 1ps

module arts_div import arts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctrl_t        ctrl,
  input  logic [REM_W-1:0] rem_init,
  input  logic [VAL_W-1:0] num_init,
  input  logic [SUM_W-1:0] den,
  output logic [VAL_W-1:0] quot,
  output logic             more
);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] q_r, q_nxt;
  logic [SUM_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_sh;
  logic             ge;

  assign rem_sh = {rem_r[REM_W-2:0], q_r[VAL_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      rem_nxt = rem_init;
      q_nxt   = num_init;
      den_nxt = den;
      cnt_nxt = ctrl.steps;
    end else if (ctrl.step) begin
      rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      q_nxt   = {q_r[VAL_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign quot = q_r;
  assign more = cnt_r != CNT_W'(1);

endmodule

// ===== sv/artanh_series_summer.sv =====
// Top level of the artanh series summer: microcode sequencer, datapath and ports.
// Depends on arts_pkg and instantiates arts_div.
`timescale 1ns / 1ps

// The block takes one signed Q0.31 argument on the in_ stream and sums the
// series x^(2n+1)/(2n+1). For each term it sends one result on the out_
// stream: index, term, partial sum and relative error estimate, with tlast
// on the final result of the run and tuser set when tolerance mode ran into
// the term cap. Mode, term count and tolerance are set on the cfg_ port;
// the user is to set them only while the block is idle; the block does not enforce this.
// A request is taken only while the sequencer sits in its idle step. Setup
// of x squared is a multiply and then a rounding step; each term is then paced
// by the shared divider that produces one quotient bit a cycle for the next
// term (32 bits) and, unless it is skipped, for the estimate (31 bits).
// Results leave through an output register; when the receiver stalls the
// sequencer waits before writing the next result into it.
// Reset returns the sequencer to idle, empties the output register and
// loads the register defaults: tolerance mode, 8 terms, tolerance 2147484.
module artanh_series_summer import arts_pkg::*; #(
  parameter int MAX_TERMS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [VAL_W-1:0]  in_tdata,   // x_value
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // term_index, term_value, partial_sum, error_estimate
  output logic              out_tlast,  // last_term
  output logic              out_tuser,  // limit_hit
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [EST_W-1:0]  cfg_data
);

  localparam int N_W = $clog2(MAX_TERMS + 1);

  logic             stop_mode_r, stop_mode_nxt;
  logic [6:0]       term_limit_r, term_limit_nxt;
  logic [EST_W-1:0] tol_r, tol_nxt;

  logic [PC_W-1:0]  pc_r, pc_nxt;
  uword_t           uw;
  logic             jump;

  logic [VAL_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  logic [VAL_W-1:0]        x2_r, x2_nxt;
  logic [VAL_W-1:0]        pw_r, pw_nxt;
  logic [VAL_W-1:0]        pnx_r, pnx_nxt;
  logic [VAL_W-1:0]        nmag_r, nmag_nxt;
  logic [2*VAL_W-1:0]      prod_r, prod_nxt;
  logic [N_W-1:0]          n_r, n_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [VAL_W-1:0] tval_r, tval_nxt;
  logic [EST_W-1:0]        est_r, est_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic [VAL_W-1:0]    mul_a, mul_b;
  logic [VAL_W-1:0]    prod_rnd;
  logic [EST_W-1:0]    tmag;
  logic [VAL_W-1:0]    tneg;
  logic [SUM_W:0]      sum_ext;
  logic [SUM_W-1:0]    smag;
  logic                sum_zero;
  logic                skip_div;
  logic [6:0]          limit;
  logic [7:0]          n_done;
  logic                cap_reached, tol_done, run_last, run_hit;
  div_ctrl_t           div_ctrl;
  logic [REM_W-1:0]    div_rem_init;
  logic [VAL_W-1:0]    div_num_init;
  logic [SUM_W-1:0]    div_den;
  logic [VAL_W-1:0]    div_quot;
  logic                div_more;

  assign uw = ucode_rom(pc_r);

  // Configuration registers.
  always_comb begin
    stop_mode_nxt  = stop_mode_r;
    term_limit_nxt = term_limit_r;
    tol_nxt        = tol_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_STOP_MODE:  stop_mode_nxt  = cfg_data[0];
        CFG_TERM_LIMIT: term_limit_nxt = cfg_data[6:0];
        CFG_TOLERANCE:  tol_nxt        = cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath terms.
  assign prod_rnd = round_shift(prod_r);
  assign tmag     = (nmag_r > {1'b0, TERM_CAP}) ? TERM_CAP : nmag_r[EST_W-1:0];
  assign tneg     = {1'b0, tmag};
  assign sum_ext  = {sum_r[SUM_W-1], sum_r} + {{(SUM_W+1-VAL_W){tval_nxt[VAL_W-1]}}, tval_nxt};
  assign smag     = sum_r[SUM_W-1] ? (SUM_W)'(-sum_r) : SUM_W'(sum_r);
  assign sum_zero = sum_r == '0;
  assign skip_div = sum_zero || ({{(SUM_W-VAL_W){1'b0}}, div_quot} >= smag);

  assign limit = (term_limit_r == 7'd0) ? 7'd1 :
                 (term_limit_r > 7'(MAX_TERMS)) ? 7'(MAX_TERMS) : term_limit_r;
  assign n_done      = 8'(n_r) + 8'd1;
  assign cap_reached = n_done >= 8'(MAX_TERMS);
  assign tol_done    = est_r <= tol_r;
  assign run_last    = cap_reached || (stop_mode_r ? tol_done : (n_done >= {1'b0, limit}));
  assign run_hit     = stop_mode_r && !tol_done && cap_reached;

  assign mul_a = (uw.op == OP_MUL_X2) ? mag_r : pw_r;
  assign mul_b = (uw.op == OP_MUL_X2) ? mag_r : x2_r;

  always_comb begin
    case (uw.cond)
      JC_NEVER:    jump = 1'b0;
      JC_ALWAYS:   jump = 1'b1;
      JC_NO_REQ:   jump = !in_tvalid;
      JC_DIV_MORE: jump = div_more;
      JC_SKIP:     jump = skip_div;
      JC_OUT_FULL: jump = out_valid_r && !out_tready;
      JC_LAST:     jump = run_last;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? uw.target : pc_r + PC_W'(1);
  end

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    x2_nxt        = x2_r;
    pw_nxt        = pw_r;
    pnx_nxt       = pnx_r;
    nmag_nxt      = nmag_r;
    prod_nxt      = prod_r;
    n_nxt         = n_r;
    sum_nxt       = sum_r;
    tval_nxt      = neg_r ? -tneg : tneg;
    est_nxt       = est_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_hit_nxt   = out_hit_r;
    div_ctrl      = '{load: 1'b0, step: uw.op == OP_DIV, steps: DIV_TERM_STEPS};
    div_rem_init  = '0;
    div_num_init  = prod_rnd + VAL_W'(n_r) + VAL_W'(1);
    div_den       = SUM_W'({n_r, 1'b1}) + SUM_W'(2);
    case (uw.op)
      OP_ACCEPT: begin
        if (in_tvalid) begin
          neg_nxt  = in_tdata[VAL_W-1];
          mag_nxt  = in_tdata[VAL_W-1] ? -in_tdata : in_tdata;
          pw_nxt   = mag_nxt;
          nmag_nxt = mag_nxt;
          n_nxt    = '0;
          sum_nxt  = '0;
        end
      end
      OP_MUL_X2: prod_nxt = mul_a * mul_b;
      OP_SET_X2: x2_nxt = prod_rnd;
      OP_TERM: begin
        prod_nxt = mul_a * mul_b;
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          sum_nxt = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum_nxt = sum_ext[SUM_W-1:0];
        end
      end
      OP_PNEXT: begin
        pnx_nxt       = prod_rnd;
        div_ctrl.load = 1'b1;
      end
      OP_NMAG: begin
        nmag_nxt       = div_quot;
        est_nxt        = sum_zero ? '0 : EST_CAP;
        div_ctrl.load  = 1'b1;
        div_ctrl.steps = DIV_EST_STEPS;
        div_rem_init   = REM_W'(div_quot);
        div_num_init   = '0;
        div_den        = smag;
      end
      OP_EST: est_nxt = div_quot[EST_W-1:0];
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {1'b0, est_r, sum_r, tval_r, IDX_W'(n_r)};
        out_last_nxt  = run_last;
        out_hit_nxt   = run_hit;
      end
      OP_ADVANCE: begin
        n_nxt  = n_r + N_W'(1);
        pw_nxt = pnx_r;
      end
      default: ;
    endcase
  end

  arts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .den      (div_den),
    .quot     (div_quot),
    .more     (div_more)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_mode_r  <= 1'b1;
      term_limit_r <= 7'd8;
      tol_r        <= 31'd2147484;
      pc_r         <= PC_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      stop_mode_r  <= stop_mode_nxt;
      term_limit_r <= term_limit_nxt;
      tol_r        <= tol_nxt;
      pc_r         <= pc_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    x2_r       <= x2_nxt;
    pw_r       <= pw_nxt;
    pnx_r      <= pnx_nxt;
    nmag_r     <= nmag_nxt;
    prod_r     <= prod_nxt;
    n_r        <= n_nxt;
    sum_r      <= sum_nxt;
    if (uw.op == OP_TERM) begin
      tval_r <= tval_nxt;
    end
    est_r      <= est_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign in_tready  = uw.op == OP_ACCEPT;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_hit_r;

  a_hit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("cap flag on a result that does not end the run");

  a_hit_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[IDX_W-1:0] == IDX_W'(MAX_TERMS - 1))
    else $error("cap flag before the term cap");

  a_est_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    uw.op == OP_EST |-> sum_r != '0)
    else $error("estimate division ran with a zero partial sum");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    uw.op == OP_EMIT |-> !out_valid_r)
    else $error("result written over a waiting result");

endmodule
